>>> rtl/core/cfp_pkg.sv
`timescale 1ns / 1ps
// Package for the camera frame parser: phase codes, framing bytes, register
// indexes and the per-colour result record. No dependencies.
package cfp_pkg;

  // Framing bytes
  localparam logic [7:0] HDR_BYTE  = 8'hFE;
  localparam logic [7:0] TAIL_BYTE = 8'hEF;

  // Payload bytes that take part in the decode (four triples)
  localparam int DECODE_BYTES = 12;
  localparam int COLOUR_BYTES = 6;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CENTER_W = 10;
  localparam int TARGET_W = 8;
  localparam int VALUE_W  = 15;
  localparam int ERROR_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_TARGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_TARGET = 2'd2;

  // Register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RESET     = 10'd320;
  localparam logic [TARGET_W-1:0] RED_TARGET_RESET   = 8'd30;
  localparam logic [TARGET_W-1:0] GREEN_TARGET_RESET = 8'd29;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_TAIL     = 3'd4
  } phase_t;

  // Decoded fields of one colour
  typedef struct packed {
    logic        [VALUE_W-1:0] position;
    logic        [VALUE_W-1:0] distance;
    logic signed [ERROR_W-1:0] position_error;
    logic signed [ERROR_W-1:0] distance_error;
  } colour_t;

endpackage

>>> rtl/core/cfp_rx_if.sv
`timescale 1ns / 1ps
// Received-byte channel: valid/ready handshake carrying one byte per transfer.
// Depends on cfp_pkg.
interface cfp_rx_if;
  logic                       valid;
  logic                       ready;
  logic [cfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/cfp_result_if.sv
`timescale 1ns / 1ps
// Decoded frame channel: valid/ready handshake carrying the eight result fields.
// Depends on cfp_pkg.
interface cfp_result_if;
  logic                               valid;
  logic                               ready;
  logic        [cfp_pkg::VALUE_W-1:0] red_position;
  logic        [cfp_pkg::VALUE_W-1:0] red_distance;
  logic signed [cfp_pkg::ERROR_W-1:0] red_position_error;
  logic signed [cfp_pkg::ERROR_W-1:0] red_distance_error;
  logic        [cfp_pkg::VALUE_W-1:0] green_position;
  logic        [cfp_pkg::VALUE_W-1:0] green_distance;
  logic signed [cfp_pkg::ERROR_W-1:0] green_position_error;
  logic signed [cfp_pkg::ERROR_W-1:0] green_distance_error;

  modport source (
    output valid, input ready,
    output red_position, output red_distance,
    output red_position_error, output red_distance_error,
    output green_position, output green_distance,
    output green_position_error, output green_distance_error
  );
  modport sink (
    input valid, output ready,
    input red_position, input red_distance,
    input red_position_error, input red_distance_error,
    input green_position, input green_distance,
    input green_position_error, input green_distance_error
  );
endinterface

>>> rtl/core/cfp_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake carrying register index
// and write data. Depends on cfp_pkg.
interface cfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfp_pkg::CFG_IDX_W-1:0]  index;
  logic [cfp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/cfp_colour_decode.sv
`timescale 1ns / 1ps
// Decode of one colour: two decimal triples into position and distance, and
// their errors against centre and target. Depends on cfp_pkg.
module cfp_colour_decode (
  input  logic [cfp_pkg::COLOUR_BYTES-1:0][cfp_pkg::BYTE_W-1:0] bytes,
  input  logic [cfp_pkg::CENTER_W-1:0]                          center_x,
  input  logic [cfp_pkg::TARGET_W-1:0]                          target,
  output cfp_pkg::colour_t                                      colour
);

  logic [cfp_pkg::VALUE_W-1:0] position;
  logic [cfp_pkg::VALUE_W-1:0] distance;
  logic                        not_seen;

  // Weight digits by 100, 10, 1 (constant multiplies, max 28305)
  assign position = cfp_pkg::VALUE_W'(bytes[0]) * cfp_pkg::VALUE_W'(100)
                  + cfp_pkg::VALUE_W'(bytes[1]) * cfp_pkg::VALUE_W'(10)
                  + cfp_pkg::VALUE_W'(bytes[2]);
  assign distance = cfp_pkg::VALUE_W'(bytes[3]) * cfp_pkg::VALUE_W'(100)
                  + cfp_pkg::VALUE_W'(bytes[4]) * cfp_pkg::VALUE_W'(10)
                  + cfp_pkg::VALUE_W'(bytes[5]);

  assign not_seen = (position == '0) && (distance == '0);

  // Errors wrap to 16 bits; zero them when the colour was not seen
  always_comb begin
    colour.position = position;
    colour.distance = distance;
    if (not_seen) begin
      colour.position_error = '0;
      colour.distance_error = '0;
    end else begin
      colour.position_error = cfp_pkg::ERROR_W'(position) - cfp_pkg::ERROR_W'(center_x);
      colour.distance_error = cfp_pkg::ERROR_W'(distance) - cfp_pkg::ERROR_W'(target);
    end
  end

endmodule

>>> rtl/core/camera_frame_parser_decoder.sv
`timescale 1ns / 1ps
// Camera frame parser top level: framing state machine, payload store,
// configuration registers and result register. Depends on cfp_pkg, the three
// channel interfaces and cfp_colour_decode.
//
// Usage:
//   rx carries one received byte per transfer. Frames are 0xFE, a length byte,
//   payload (at least one byte), an 8-bit wrapping sum of the payload, 0xEF.
//   Any unexpected byte drops the parser back to idle.
//   result carries one decoded record per good frame: red and green position
//   and distance from payload bytes 0..11 as decimal triples, plus errors
//   against the configured centre and target distances.
//   cfg writes index 0 center_x, 1 red target, 2 green target; other indexes
//   are ignored. cfg is always ready; write only while the block is idle.
// Throughput: one byte per cycle outside the stall below. Latency: the record is
//   valid the cycle after the tail byte transfers, from the result register.
// Reset: parser idle, payload store and sum cleared, registers back to
//   320 / 30 / 29, no result pending.
// Stall: while a record waits on result, bytes keep transferring; only a byte
//   arriving in the tail phase is held off until the record is taken.
module camera_frame_parser_decoder (
  input  logic                 clk,
  input  logic                 rst,
  cfp_rx_if.sink               rx,
  cfp_result_if.source         result,
  cfp_cfg_if.sink              cfg
);

  cfp_pkg::phase_t phase, phase_next;

  logic [cfp_pkg::BYTE_W-1:0]   running_sum;
  logic [cfp_pkg::BYTE_W-1:0]   frame_length;
  logic [cfp_pkg::BYTE_W-1:0]   byte_count;
  logic [cfp_pkg::BYTE_W-1:0]   count_inc;
  logic [cfp_pkg::BYTE_W-1:0]   store [cfp_pkg::DECODE_BYTES];

  logic [cfp_pkg::CENTER_W-1:0] center_x;
  logic [cfp_pkg::TARGET_W-1:0] red_target;
  logic [cfp_pkg::TARGET_W-1:0] green_target;

  logic rx_fire;
  logic load_length;
  logic take_payload;
  logic emit;
  logic out_valid;

  logic [cfp_pkg::COLOUR_BYTES-1:0][cfp_pkg::BYTE_W-1:0] red_bytes;
  logic [cfp_pkg::COLOUR_BYTES-1:0][cfp_pkg::BYTE_W-1:0] green_bytes;
  cfp_pkg::colour_t red_dec, green_dec;
  cfp_pkg::colour_t red_out, green_out;

  // Hold off only a tail-phase byte while a record is stalled
  assign rx.ready  = !(out_valid && !result.ready && (phase == cfp_pkg::PH_TAIL));
  assign rx_fire   = rx.valid && rx.ready;
  assign count_inc = byte_count + 8'd1;
  assign cfg.ready = 1'b1;

  // Next phase
  always_comb begin
    phase_next = phase;
    if (rx_fire) begin
      unique case (phase)
        cfp_pkg::PH_IDLE:
          phase_next = (rx.rx_byte == cfp_pkg::HDR_BYTE) ? cfp_pkg::PH_LENGTH
                                                         : cfp_pkg::PH_IDLE;
        cfp_pkg::PH_LENGTH:   phase_next = cfp_pkg::PH_PAYLOAD;
        cfp_pkg::PH_PAYLOAD:
          phase_next = (count_inc >= frame_length) ? cfp_pkg::PH_CHECKSUM
                                                   : cfp_pkg::PH_PAYLOAD;
        cfp_pkg::PH_CHECKSUM:
          phase_next = (rx.rx_byte == running_sum) ? cfp_pkg::PH_TAIL
                                                   : cfp_pkg::PH_IDLE;
        cfp_pkg::PH_TAIL:     phase_next = cfp_pkg::PH_IDLE;
        default:              phase_next = cfp_pkg::PH_IDLE;
      endcase
    end
  end

  // Phase-driven controls
  always_comb begin
    load_length  = 1'b0;
    take_payload = 1'b0;
    emit         = 1'b0;
    unique case (phase)
      cfp_pkg::PH_LENGTH:  load_length  = rx_fire;
      cfp_pkg::PH_PAYLOAD: take_payload = rx_fire;
      cfp_pkg::PH_TAIL:    emit         = rx_fire && (rx.rx_byte == cfp_pkg::TAIL_BYTE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfp_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Length, count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      frame_length <= '0;
      byte_count   <= '0;
    end else if (load_length) begin
      running_sum  <= '0;
      frame_length <= rx.rx_byte;
      byte_count   <= '0;
    end else if (take_payload) begin
      running_sum  <= running_sum + rx.rx_byte;
      byte_count   <= count_inc;
    end
  end

  // Payload store: only the decoded window is kept, later bytes are summed only
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cfp_pkg::DECODE_BYTES; i++) begin
        store[i] <= '0;
      end
    end else if (take_payload) begin
      for (int i = 0; i < cfp_pkg::DECODE_BYTES; i++) begin
        if (byte_count == cfp_pkg::BYTE_W'(i)) begin
          store[i] <= rx.rx_byte;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= cfp_pkg::CENTER_X_RESET;
      red_target   <= cfp_pkg::RED_TARGET_RESET;
      green_target <= cfp_pkg::GREEN_TARGET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        cfp_pkg::REG_CENTER_X:     center_x     <= cfg.data;
        cfp_pkg::REG_RED_TARGET:   red_target   <= cfg.data[cfp_pkg::TARGET_W-1:0];
        cfp_pkg::REG_GREEN_TARGET: green_target <= cfg.data[cfp_pkg::TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode both colours from the store
  always_comb begin
    for (int i = 0; i < cfp_pkg::COLOUR_BYTES; i++) begin
      red_bytes[i]   = store[i];
      green_bytes[i] = store[i + cfp_pkg::COLOUR_BYTES];
    end
  end

  cfp_colour_decode u_red (
    .bytes    (red_bytes),
    .center_x (center_x),
    .target   (red_target),
    .colour   (red_dec)
  );

  cfp_colour_decode u_green (
    .bytes    (green_bytes),
    .center_x (center_x),
    .target   (green_target),
    .colour   (green_dec)
  );

  // Result register: load on a good tail, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      red_out   <= red_dec;
      green_out <= green_dec;
    end
  end

  assign result.valid                = out_valid;
  assign result.red_position         = red_out.position;
  assign result.red_distance         = red_out.distance;
  assign result.red_position_error   = red_out.position_error;
  assign result.red_distance_error   = red_out.distance_error;
  assign result.green_position       = green_out.position;
  assign result.green_distance       = green_out.distance;
  assign result.green_position_error = green_out.position_error;
  assign result.green_distance_error = green_out.distance_error;

`ifndef ASSERT_OFF
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> result.valid)
    else $error("good tail did not raise result valid");

  a_rose_from_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(phase) == cfp_pkg::PH_TAIL)
    else $error("result raised outside the tail phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == cfp_pkg::PH_PAYLOAD) |-> (byte_count <= frame_length))
    else $error("payload count ran past frame length");

  a_red_unseen: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.red_position == '0 && result.red_distance == '0)
      |-> (result.red_position_error == '0 && result.red_distance_error == '0))
    else $error("red errors nonzero while red not seen");

  a_green_unseen: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.green_position == '0 && result.green_distance == '0)
      |-> (result.green_position_error == '0 && result.green_distance_error == '0))
    else $error("green errors nonzero while green not seen");
`endif

endmodule

>>> sim/cfp_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the camera frame parser: watches the byte, result and register
// channels, predicts each decoded frame and compares it. Depends on cfp_pkg
// and the three channel interfaces.
module cfp_frame_checker
  import cfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  cfp_rx_if      rx,
  cfp_result_if  result,
  cfp_cfg_if     cfg,
  output int     pending,
  output logic   parse_idle,
  output int     failures
);

  localparam int STORE_DEPTH = 16;

  typedef struct packed {
    colour_t red;
    colour_t green;
  } frame_rec_t;

  // Shadow registers and parser state
  logic [CENTER_W-1:0] center_x;
  logic [TARGET_W-1:0] red_target;
  logic [TARGET_W-1:0] green_target;
  phase_t              phase;
  logic [7:0]          run_sum;
  logic [7:0]          frame_len;
  logic [7:0]          byte_cnt;
  logic [7:0]          store [STORE_DEPTH];
  frame_rec_t          decoded_q [$];
  int                  pending_cnt = 0;
  logic                idle_flag = 1'b1;
  int                  fail_cnt = 0;

  assign pending    = pending_cnt;
  assign parse_idle = idle_flag;
  assign failures   = fail_cnt;

  // Read two decimal triples from the store and form the errors of one colour
  function automatic colour_t decode_colour(input int base,
                                            input logic [TARGET_W-1:0] target);
    colour_t c;
    int      pos;
    int      dis;
    int      perr;
    int      derr;
    pos  = int'(store[base]) * 100 + int'(store[base+1]) * 10 + int'(store[base+2]);
    dis  = int'(store[base+3]) * 100 + int'(store[base+4]) * 10 + int'(store[base+5]);
    perr = pos - int'(center_x);
    derr = dis - int'(target);
    c.position       = pos[VALUE_W-1:0];
    c.distance       = dis[VALUE_W-1:0];
    c.position_error = perr[ERROR_W-1:0];
    c.distance_error = derr[ERROR_W-1:0];
    // Colour not seen: zero both errors
    if (pos == 0 && dis == 0) begin
      c.position_error = '0;
      c.distance_error = '0;
    end
    return c;
  endfunction

  // Advance the framing state by one byte; returns 1 when a frame completes
  function automatic bit parse_byte(input logic [7:0] b, output frame_rec_t rec);
    bit done;
    done = 1'b0;
    rec  = '0;
    case (phase)
      PH_IDLE: begin
        phase = (b == HDR_BYTE) ? PH_LENGTH : PH_IDLE;
      end
      PH_LENGTH: begin
        run_sum   = '0;
        frame_len = b;
        byte_cnt  = '0;
        phase     = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // Bytes past the store depth count in the sum only
        if (byte_cnt < STORE_DEPTH) store[byte_cnt] = b;
        run_sum  = run_sum + b;
        byte_cnt = byte_cnt + 8'd1;
        if (byte_cnt >= frame_len) phase = PH_CHECKSUM;
      end
      PH_CHECKSUM: begin
        phase = (b == run_sum) ? PH_TAIL : PH_IDLE;
      end
      PH_TAIL: begin
        if (b == TAIL_BYTE) begin
          rec.red   = decode_colour(0, red_target);
          rec.green = decode_colour(COLOUR_BYTES, green_target);
          done      = 1'b1;
        end
        phase = PH_IDLE;
      end
      default: begin
        phase = PH_IDLE;
      end
    endcase
    return done;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    frame_rec_t rec;
    if (rst) begin
      center_x     = CENTER_X_RESET;
      red_target   = RED_TARGET_RESET;
      green_target = GREEN_TARGET_RESET;
      phase        = PH_IDLE;
      run_sum      = '0;
      frame_len    = '0;
      byte_cnt     = '0;
      for (int i = 0; i < STORE_DEPTH; i++) store[i] = '0;
      decoded_q.delete();
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CENTER_X:     center_x     = cfg.data[CENTER_W-1:0];
          REG_RED_TARGET:   red_target   = cfg.data[TARGET_W-1:0];
          REG_GREEN_TARGET: green_target = cfg.data[TARGET_W-1:0];
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest decoded frame
      if (result.valid && result.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with no decoded frame outstanding");
          fail_cnt++;
        end else begin
          rec = decoded_q.pop_front();
          check_field("red_position", int'(rec.red.position), int'(result.red_position));
          check_field("red_distance", int'(rec.red.distance), int'(result.red_distance));
          check_field("red_position_error", int'(rec.red.position_error),
                      int'(result.red_position_error));
          check_field("red_distance_error", int'(rec.red.distance_error),
                      int'(result.red_distance_error));
          check_field("green_position", int'(rec.green.position),
                      int'(result.green_position));
          check_field("green_distance", int'(rec.green.distance),
                      int'(result.green_distance));
          check_field("green_position_error", int'(rec.green.position_error),
                      int'(result.green_position_error));
          check_field("green_distance_error", int'(rec.green.distance_error),
                      int'(result.green_distance_error));
        end
      end

      // Step the parser on each byte transfer
      if (rx.valid && rx.ready) begin
        if (parse_byte(rx.rx_byte, rec)) decoded_q.push_back(rec);
      end
    end
    pending_cnt <= decoded_q.size();
    idle_flag   <= (phase == PH_IDLE);
  end

endmodule

>>> sim/camera_frame_parser_decoder_test.sv
`timescale 1ns / 1ps
// Testbench top for the camera frame parser: clock, reset, byte and register
// stimulus, result back-pressure and verdict. Depends on cfp_pkg, the channel
// interfaces, camera_frame_parser_decoder and cfp_frame_checker.
module camera_frame_parser_decoder_test;
  import cfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_BYTES    = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Zero-length frame, wrong sum, then a wrong tail that is itself a header
  // byte followed by bytes that would form a frame if it were reused
  localparam logic [7:0] DIRECTED_BYTES [18] = '{
    HDR_BYTE, 8'h00, 8'hFF, 8'hFF, TAIL_BYTE,
    HDR_BYTE, 8'h01, 8'h05, 8'h06,
    HDR_BYTE, 8'h01, 8'h05, 8'h05, HDR_BYTE, 8'h00, 8'h00, 8'h00, TAIL_BYTE
  };

  logic clk = 1'b0;
  logic rst;
  int   pending;
  logic parse_idle;
  int   failures;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   bytes_sent = 0;
  int   quiet_cycles = 0;

  cfp_rx_if     rx_ch ();
  cfp_result_if res_ch ();
  cfp_cfg_if    cfg_ch ();

  camera_frame_parser_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  cfp_frame_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .pending    (pending),
    .parse_idle (parse_idle),
    .failures   (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Randomly stall the result channel
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("camera_frame_parser_decoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the byte channel until every decoded frame has come out
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Send one frame with random content; optionally corrupt sum or tail
  task automatic send_frame(input logic [7:0] len, input bit bad_sum, input bit bad_tail);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] tail;
    int         n;
    int         style;
    sum   = '0;
    n     = (len == 8'd0) ? 1 : int'(len);
    style = $urandom_range(9);
    send_byte(HDR_BYTE);
    send_byte(len);
    for (int i = 0; i < n; i++) begin
      // Mostly decimal digits; sometimes full bytes or one colour blanked
      if (style >= 8 && i < DECODE_BYTES && (i / COLOUR_BYTES) == style - 8) b = 8'd0;
      else if (style >= 6 && style < 8) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(9));
      send_byte(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
    tail = TAIL_BYTE;
    if (bad_tail) begin
      while (tail == TAIL_BYTE) tail = 8'($urandom_range(255));
    end
    send_byte(tail);
  endtask

  // One stretch of random traffic under one register setting and idle mix
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [CFG_DATA_W-1:0] cx,
                           input logic [CFG_DATA_W-1:0] red_t,
                           input logic [CFG_DATA_W-1:0] green_t);
    int         start;
    int         r;
    bit         paused;
    logic [7:0] len;
    paused = 1'b0;
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_RED_TARGET, red_t);
    write_reg(REG_GREEN_TARGET, green_t);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_ch.valid   <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      // Halfway through, hold off until the block has delivered everything
      if (!paused && bytes_sent - start >= PHASE_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 10) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        r = $urandom_range(99);
        if (r < 70) len = 8'($urandom_range(12, 16));
        else if (r < 85) len = 8'($urandom_range(0, 11));
        else if (r < 97) len = 8'($urandom_range(17, 40));
        else len = 8'($urandom_range(41, 255));
        send_frame(len, $urandom_range(99) < 8, $urandom_range(99) < 6);
      end
    end
    // Walk the parser back to idle before the next register writes
    drain_results();
    while (!parse_idle) begin
      send_byte(8'h00);
      drain_results();
    end
  endtask

  initial begin
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Special framing cases under the reset register values
    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    drain_results();

    // Register extremes first, then random settings; upper data bits dropped
    run_phase(0, 0, '0, '0, '0);
    run_phase(56, 0, 10'h3FF, 10'h3FF, 10'h0FF);
    run_phase(0, 56, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
              CFG_DATA_W'($urandom));
    run_phase(30, 30, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(255)),
              CFG_DATA_W'($urandom_range(255)));

    if (failures == 0) begin
      $display("camera_frame_parser_decoder: match");
    end else begin
      $display("camera_frame_parser_decoder: mismatch");
    end
    $finish;
  end

endmodule
